// ===== sv/scp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sound channel picker.
package scp_pkg;

  localparam int DYN_CHANNELS_DEF = 8;
  localparam int TIME_BITS_DEF    = 32;

  localparam int OP_W   = 2;
  localparam int ENT_W  = 16;
  localparam int SUB_W  = 4;
  localparam int SND_W  = 10;
  localparam int LEN_W  = 24;
  localparam int NOW_W  = 32;
  localparam int REL_W  = 3;
  localparam int IDX_W  = 3;

  // sub-channel codes with a meaning of their own
  localparam logic [SUB_W-1:0] SUB_NONE = 4'h0;
  localparam logic [SUB_W-1:0] SUB_ANY  = 4'hF;

  localparam logic [SND_W-1:0] SND_IDLE = '0;

  typedef enum logic [OP_W-1:0] {
    OP_START    = 2'd0,
    OP_RELEASE  = 2'd1,
    OP_STOP_ALL = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_REL_RD,
    ST_REL_WR,
    ST_SWEEP,
    ST_EMIT
  } state_t;

endpackage

// ===== sv/sound_channel_picker.sv =====
`timescale 1ns / 1ps
// Dynamic voice channel allocator with voice stealing, built around a channel table RAM.
// Start: one table read per cycle until a match or the last channel, then one write-back;
// release reads and writes back one entry; stop-all reads every entry and clears the active
// ones; other requests go straight to the result. One transaction at a time, and the channel
// table has a single read port.
// Reset (synchronous, rst_n low): table valid bits, view entity and control clear at once.
module sound_channel_picker
  import scp_pkg::*;
#(
  parameter int DYNAMIC_CHANNELS = DYN_CHANNELS_DEF,
  parameter int TIME_BITS        = TIME_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [ENT_W-1:0]        cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         in_operation,
  input  logic [ENT_W-1:0]        in_entity,
  input  logic signed [SUB_W-1:0] in_sub_channel,
  input  logic [SND_W-1:0]        in_sound_id,
  input  logic [LEN_W-1:0]        in_sound_length,
  input  logic [NOW_W-1:0]        in_now_time,
  input  logic [REL_W-1:0]        in_release_index,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_granted,
  output logic [IDX_W-1:0]        out_channel_index,
  output logic [SND_W-1:0]        out_evicted_sound
);

  localparam int IW = (DYNAMIC_CHANNELS > 1) ? $clog2(DYNAMIC_CHANNELS) : 1;
  localparam int CW = IW + 1;
  localparam int AW = (IW > REL_W) ? IW : REL_W;
  localparam int TB = TIME_BITS;
  // table word: {entity, sub-channel, sound, end time}
  localparam int W  = TB + SND_W + SUB_W + ENT_W;
  localparam logic [CW-1:0] CNT_END  = CW'(DYNAMIC_CHANNELS);
  localparam logic [IW-1:0] IDX_LAST = IW'(DYNAMIC_CHANNELS - 1);
  localparam logic [TB-1:0] TSIGN    = {1'b1, {(TB-1){1'b0}}};
  // above every key; at 64 bits the most positive time left stays unchosen
  localparam logic [TB:0]   BEST_INIT = {1'(TB < 64), {TB{1'b1}}};

  // ---------------------------------------------------------------- channel table
  logic [W-1:0]                mem [DYNAMIC_CHANNELS];
  logic [DYNAMIC_CHANNELS-1:0] vld_r;
  logic                        rd_en, wr_en;
  logic [IW-1:0]               rd_addr, wr_addr;
  logic [W-1:0]                wr_data;
  logic [W-1:0]                rd_q_r;
  logic                        rd_vld_r;
  logic                        eval_vld_r;
  logic [IW-1:0]               eval_idx_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // entries never written read as zero: idle channel, owner 0, end 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      rd_vld_r   <= 1'b0;
      eval_vld_r <= 1'b0;
      eval_idx_r <= '0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      eval_vld_r <= rd_en;
      if (rd_en) begin
        eval_idx_r <= rd_addr;
        rd_vld_r   <= vld_r[rd_addr];
      end
    end
  end

  logic [W-1:0]     e;
  logic [TB-1:0]    e_end;
  logic [SND_W-1:0] e_snd;
  logic [SUB_W-1:0] e_sub;
  logic [ENT_W-1:0] e_ent;

  assign e     = rd_vld_r ? rd_q_r : '0;
  assign e_end = e[TB-1:0];
  assign e_snd = e[TB+SND_W-1:TB];
  assign e_sub = e[TB+SND_W+SUB_W-1:TB+SND_W];
  assign e_ent = e[W-1:W-ENT_W];

  // ---------------------------------------------------------------- request hold
  logic [ENT_W-1:0] rq_ent_r;
  logic [SUB_W-1:0] rq_sub_r;
  logic [SND_W-1:0] rq_sid_r;
  logic [LEN_W-1:0] rq_len_r;
  logic [NOW_W-1:0] rq_now_r;
  logic [REL_W-1:0] rq_rel_r;
  logic [ENT_W-1:0] view_r;
  logic             in_acc;

  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rq_ent_r <= in_entity;
      rq_sub_r <= unsigned'(in_sub_channel);
      rq_sid_r <= in_sound_id;
      rq_len_r <= in_sound_length;
      rq_now_r <= in_now_time;
      rq_rel_r <= in_release_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_r <= '0;
    end else if (cfg_wr_en) begin
      view_r <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------- scan datapath
  logic [TB-1:0] now_t, end_new, key;
  logic [TB:0]   key_ext;
  logic          is_match, is_guard, better;
  logic          in_rel_ok;
  logic [AW-1:0] rel_ext;

  assign now_t    = TB'(rq_now_r);
  assign end_new  = now_t + TB'(rq_len_r);
  // bias the sign bit so an unsigned compare orders signed time left
  assign key      = (e_end - now_t) ^ TSIGN;
  assign key_ext  = {1'b0, key};
  assign is_match = (rq_sub_r != SUB_NONE) && (e_ent == rq_ent_r) &&
                    ((e_sub == rq_sub_r) || (rq_sub_r == SUB_ANY));
  // listener's own active voices are off limits to other entities
  assign is_guard = (e_ent == view_r) && (rq_ent_r != view_r) && (e_snd != SND_IDLE);
  assign rel_ext  = AW'(rq_rel_r);
  assign in_rel_ok = {1'b0, AW'(in_release_index)} < (AW+1)'(DYNAMIC_CHANNELS);

  // ---------------------------------------------------------------- control
  state_t           state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [TB:0]      best_r, best_nxt;
  logic             found_r, found_nxt;
  logic [IW-1:0]    pick_r, pick_nxt;
  logic [SND_W-1:0] evs_r, evs_nxt;
  logic             res_g_r, res_g_nxt;
  logic [IDX_W-1:0] res_idx_r, res_idx_nxt;
  logic [SND_W-1:0] res_ev_r, res_ev_nxt;
  logic             out_free;
  logic             better_ok;

  assign better    = key_ext < best_r;
  assign better_ok = !is_guard && better;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (op_t'(in_operation))
            OP_START:    state_nxt = (in_sound_id == SND_IDLE) ? ST_EMIT : ST_SCAN;
            OP_RELEASE:  state_nxt = in_rel_ok ? ST_REL_RD : ST_EMIT;
            OP_STOP_ALL: state_nxt = ST_SWEEP;
            default:     state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_SCAN: begin
        if (eval_vld_r) begin
          if (is_match) begin
            state_nxt = ST_WRITE;
          end else if (eval_idx_r == IDX_LAST) begin
            state_nxt = (found_r || better_ok) ? ST_WRITE : ST_EMIT;
          end
        end
      end
      ST_WRITE:  state_nxt = ST_EMIT;
      ST_REL_RD: state_nxt = ST_REL_WR;
      ST_REL_WR: state_nxt = ST_EMIT;
      ST_SWEEP: begin
        if (eval_vld_r && (eval_idx_r == IDX_LAST)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = cnt_r[IW-1:0];
    wr_en       = 1'b0;
    wr_addr     = eval_idx_r;
    wr_data     = e;
    cnt_nxt     = cnt_r;
    best_nxt    = best_r;
    found_nxt   = found_r;
    pick_nxt    = pick_r;
    evs_nxt     = evs_r;
    res_g_nxt   = res_g_r;
    res_idx_nxt = res_idx_r;
    res_ev_nxt  = res_ev_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cnt_nxt     = '0;
          best_nxt    = BEST_INIT;
          found_nxt   = 1'b0;
          res_g_nxt   = 1'b0;
          res_ev_nxt  = SND_IDLE;
          res_idx_nxt = (op_t'(in_operation) == OP_RELEASE) ? IDX_W'(in_release_index) : '0;
        end
      end
      ST_SCAN: begin
        rd_en = (cnt_r < CNT_END);
        if (rd_en) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (eval_vld_r) begin
          if (is_match) begin
            pick_nxt  = eval_idx_r;
            evs_nxt   = e_snd;
            found_nxt = 1'b1;
          end else if (better_ok) begin
            best_nxt  = key_ext;
            pick_nxt  = eval_idx_r;
            evs_nxt   = e_snd;
            found_nxt = 1'b1;
          end
        end
      end
      ST_WRITE: begin
        wr_en       = 1'b1;
        wr_addr     = pick_r;
        wr_data     = {rq_ent_r, rq_sub_r, rq_sid_r, end_new};
        res_g_nxt   = 1'b1;
        res_idx_nxt = IDX_W'(pick_r);
        res_ev_nxt  = evs_r;
      end
      ST_REL_RD: begin
        rd_en   = 1'b1;
        rd_addr = rel_ext[IW-1:0];
      end
      ST_REL_WR: begin
        // end time is kept on a release
        wr_en      = 1'b1;
        wr_data    = {e_ent, e_sub, SND_IDLE, e_end};
        res_ev_nxt = e_snd;
      end
      ST_SWEEP: begin
        rd_en = (cnt_r < CNT_END);
        if (rd_en) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (eval_vld_r && (e_snd != SND_IDLE)) begin
          wr_en   = 1'b1;
          wr_data = {e_ent, e_sub, SND_IDLE, {TB{1'b0}}};
        end
      end
      ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r    <= best_nxt;
    pick_r    <= pick_nxt;
    evs_r     <= evs_nxt;
    res_g_r   <= res_g_nxt;
    res_idx_r <= res_idx_nxt;
    res_ev_r  <= res_ev_nxt;
  end

  // ---------------------------------------------------------------- result register
  logic             out_valid_r;
  logic             out_granted_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [SND_W-1:0] out_ev_r;
  logic             out_load;

  assign out_load = (state_r == ST_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // hold the payload while the consumer stalls
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_granted_r <= res_g_r;
      out_idx_r     <= res_idx_r;
      out_ev_r      <= res_ev_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_granted       = out_granted_r;
  assign out_channel_index = out_idx_r;
  assign out_evicted_sound = out_ev_r;

endmodule

// ===== sv/scp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the sound channel picker, bound to the top level.
module scp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_granted,
  input logic [2:0] out_channel_index,
  input logic [9:0] out_evicted_sound
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_granted) &&
      $stable(out_channel_index) && $stable(out_evicted_sound))
    else $error("stalled result changed");

  // one transaction in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a transaction is in flight");

  // no result appears in the cycle right after an accept
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result without processing time");

  // reset empties the result register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sound_channel_picker scp_checker u_scp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_granted       (out_granted),
  .out_channel_index (out_channel_index),
  .out_evicted_sound (out_evicted_sound)
);
